### design/dfe_pkg.sv
// Package for the delimited field extractor: sizes, transaction structs,
// search phase codes, register indexes and byte helper functions.
// No dependencies.
package dfe_pkg;

    localparam int MAX_DELIM = 8;
    localparam int MAX_TEXT  = 65536;

    localparam int BYTE_W = 8;
    localparam int WIN_W  = MAX_DELIM * BYTE_W;
    localparam int PAT_W  = 64;
    localparam int LEN_W  = 4;
    localparam int POS_W  = $clog2(MAX_TEXT) + 1;  // holds MAX_TEXT itself
    localparam int OFS_W  = 16;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 2;

    // Input transaction: one text byte
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              text_last;
    } text_t;

    // Output transaction: one result per text
    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] value_start;
        logic [OFS_W-1:0] value_length;
    } result_t;

    typedef enum logic [1:0] {
        PH_OPEN  = 2'd0,
        PH_CLOSE = 2'd1,
        PH_DONE  = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    typedef enum logic [IDX_W-1:0] {
        REG_OPEN_PATTERN  = 2'd0,
        REG_OPEN_LENGTH   = 2'd1,
        REG_CLOSE_PATTERN = 2'd2,
        REG_CLOSE_LENGTH  = 2'd3
    } reg_index_t;

    // ASCII A-Z folded to lower case, all else unchanged
    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

    // Delimiter length clipped to MAX_DELIM
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len > LEN_W'(MAX_DELIM))
        begin
            r = LEN_W'(MAX_DELIM);
        end
        return r;
    endfunction

endpackage

### design/delimited_field_extractor_core.sv
// Top level of the delimited field extractor: input stage, search state,
// result register and configuration registers.
// Depends on dfe_pkg and dfe_delim_match.
//
//  Channel   Signals                              Moves
//  --------  -----------------------------------  ------------------------------
//  text      text_valid, text_stall, text         one text byte per transaction
//  result    result_valid, result_stall, result   one result per text
//  cfg       cfg_write, cfg_index, cfg_data       register write, no read-back
//
// One byte per cycle sustained while text_stall is low. A byte is captured in
// the input stage, then the search state and the result register are updated
// from it as it advances, so result_valid rises once the text_last byte has left
// the input stage. The state recurrence (window shift plus parallel compare)
// sets the rate. Reset clears all control and search state and the registers.
// text_stall only rises when the staged byte closes a text and the result
// register still holds an untaken result that is itself stalled.
module delimited_field_extractor_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // text channel
    input  logic                        text_valid,
    output logic                        text_stall,
    input  dfe_pkg::text_t              text,
    // result channel
    output logic                        result_valid,
    input  logic                        result_stall,
    output dfe_pkg::result_t            result,
    // configuration
    input  logic                        cfg_write,
    input  logic [dfe_pkg::IDX_W-1:0]   cfg_index,
    input  logic [dfe_pkg::CFG_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [dfe_pkg::PAT_W-1:0] open_pattern_reg;
    logic [dfe_pkg::LEN_W-1:0] open_length_reg;
    logic [dfe_pkg::PAT_W-1:0] close_pattern_reg;
    logic [dfe_pkg::LEN_W-1:0] close_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_pattern_reg  <= '0;
            open_length_reg   <= '0;
            close_pattern_reg <= '0;
            close_length_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dfe_pkg::REG_OPEN_PATTERN:  open_pattern_reg  <= cfg_data;
                dfe_pkg::REG_OPEN_LENGTH:   open_length_reg   <= cfg_data[dfe_pkg::LEN_W-1:0];
                dfe_pkg::REG_CLOSE_PATTERN: close_pattern_reg <= cfg_data;
                dfe_pkg::REG_CLOSE_LENGTH:  close_length_reg  <= cfg_data[dfe_pkg::LEN_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    logic            stage_valid_reg;
    logic            stage_valid_next;
    dfe_pkg::text_t  stage_data_reg;
    logic            advance;
    logic            text_take;
    logic            result_take;

    // Bytes that do not close a text never touch the result register
    assign advance     = stage_valid_reg &
                         (~stage_data_reg.text_last | ~result_valid | ~result_stall);
    assign text_stall  = stage_valid_reg & ~advance;
    assign text_take   = text_valid & ~text_stall;
    assign result_take = result_valid & ~result_stall;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (text_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            stage_data_reg <= text;
        end
    end

    // ------------------------------------------------------------------
    // Search state
    // ------------------------------------------------------------------
    logic [dfe_pkg::WIN_W-1:0] window_reg,   window_next,   window_cur;
    logic [dfe_pkg::POS_W-1:0] position_reg, position_next, position_cur;
    dfe_pkg::phase_t           phase_reg,    phase_next,    phase_cur;
    logic [dfe_pkg::LEN_W-1:0] in_phase_reg, in_phase_next, in_phase_cur;
    logic [dfe_pkg::OFS_W-1:0] offset_reg,   offset_next,   offset_cur;
    logic [dfe_pkg::OFS_W-1:0] size_reg,     size_next,     size_cur;
    logic                      ended_reg;

    logic [dfe_pkg::LEN_W-1:0] open_len;
    logic [dfe_pkg::LEN_W-1:0] close_len;
    logic                      open_hit;
    logic                      close_hit;
    logic [dfe_pkg::WIN_W-1:0] window_shifted;
    logic [dfe_pkg::LEN_W-1:0] in_phase_inc;

    assign open_len  = dfe_pkg::eff_len(open_length_reg);
    assign close_len = dfe_pkg::eff_len(close_length_reg);

    // A new text starts from cleared per-text state
    always_comb
    begin
        if (ended_reg)
        begin
            window_cur   = '0;
            position_cur = '0;
            phase_cur    = dfe_pkg::PH_OPEN;
            in_phase_cur = '0;
            offset_cur   = '0;
            size_cur     = '0;
        end
        else
        begin
            window_cur   = window_reg;
            position_cur = position_reg;
            phase_cur    = phase_reg;
            in_phase_cur = in_phase_reg;
            offset_cur   = offset_reg;
            size_cur     = size_reg;
        end
    end

    assign window_shifted = {window_cur[dfe_pkg::WIN_W-dfe_pkg::BYTE_W-1:0],
                             stage_data_reg.text_byte};
    assign in_phase_inc   = (in_phase_cur < dfe_pkg::LEN_W'(dfe_pkg::MAX_DELIM)) ?
                            in_phase_cur + 1'b1 : in_phase_cur;

    dfe_delim_match u_open_match (
        .window  (window_shifted),
        .pattern (open_pattern_reg),
        .len     (open_len),
        .hit     (open_hit)
    );

    dfe_delim_match u_close_match (
        .window  (window_shifted),
        .pattern (close_pattern_reg),
        .len     (close_len),
        .hit     (close_hit)
    );

    always_comb
    begin
        window_next   = window_cur;
        position_next = position_cur;
        phase_next    = phase_cur;
        in_phase_next = in_phase_cur;
        offset_next   = offset_cur;
        size_next     = size_cur;
        // Bytes beyond the longest text are not searched
        if (position_cur < dfe_pkg::POS_W'(dfe_pkg::MAX_TEXT))
        begin
            if (phase_cur == dfe_pkg::PH_OPEN || phase_cur == dfe_pkg::PH_CLOSE)
            begin
                if (stage_data_reg.text_byte == '0)
                begin
                    phase_next = dfe_pkg::PH_STOP;
                end
                else
                begin
                    window_next   = window_shifted;
                    in_phase_next = in_phase_inc;
                    if (phase_cur == dfe_pkg::PH_OPEN)
                    begin
                        if (open_len != '0 && in_phase_inc >= open_len && open_hit)
                        begin
                            offset_next   = position_cur[dfe_pkg::OFS_W-1:0] + 1'b1;
                            phase_next    = dfe_pkg::PH_CLOSE;
                            in_phase_next = '0;
                        end
                    end
                    else
                    begin
                        if (close_len != '0 && in_phase_inc >= close_len && close_hit)
                        begin
                            size_next  = position_cur[dfe_pkg::OFS_W-1:0] + 1'b1
                                         - dfe_pkg::OFS_W'(close_len) - offset_cur;
                            phase_next = dfe_pkg::PH_DONE;
                        end
                    end
                end
            end
            position_next = position_cur + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            position_reg <= '0;
            phase_reg    <= dfe_pkg::PH_OPEN;
            in_phase_reg <= '0;
            offset_reg   <= '0;
            size_reg     <= '0;
            ended_reg    <= 1'b0;
        end
        else if (advance)
        begin
            window_reg   <= window_next;
            position_reg <= position_next;
            phase_reg    <= phase_next;
            in_phase_reg <= in_phase_next;
            offset_reg   <= offset_next;
            size_reg     <= size_next;
            ended_reg    <= stage_data_reg.text_last;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic             result_valid_reg;
    logic             result_valid_next;
    dfe_pkg::result_t result_reg;
    dfe_pkg::result_t result_next;
    logic             load_result;

    assign load_result = advance & stage_data_reg.text_last;

    always_comb
    begin
        result_next = '0;
        if (phase_next == dfe_pkg::PH_DONE && open_len != '0 && close_len != '0)
        begin
            result_next.found        = 1'b1;
            result_next.value_start  = offset_next;
            result_next.value_length = size_next;
        end

        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_take)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.found) |->
            (result.value_start == '0 && result.value_length == '0))
        else $error("not-found result carries offsets");

    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= dfe_pkg::POS_W'(dfe_pkg::MAX_TEXT))
        else $error("byte position beyond saturation");

    a_in_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_phase_reg <= dfe_pkg::LEN_W'(dfe_pkg::MAX_DELIM))
        else $error("phase byte count beyond saturation");

    a_hold_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall && stage_valid_reg && stage_data_reg.text_last)
            |-> text_stall)
        else $error("closing byte advanced over an untaken result");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stage_valid_reg && stage_data_reg.text_last))
        else $error("result raised without a closing byte");

endmodule

### design/dfe_delim_match.sv
// Window compare for one delimiter: folded byte compare of the newest
// bytes of the search window against the pattern. Uses dfe_pkg.
module dfe_delim_match (
    input  logic [dfe_pkg::WIN_W-1:0] window,
    input  logic [dfe_pkg::PAT_W-1:0] pattern,
    input  logic [dfe_pkg::LEN_W-1:0] len,
    output logic                      hit
);

    // One candidate per possible length; entry zero never matches
    logic [dfe_pkg::MAX_DELIM:0] hit_by_len;

    always_comb
    begin
        hit_by_len = '0;
        for (int l = 1; l <= dfe_pkg::MAX_DELIM; l++)
        begin
            hit_by_len[l] = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if (dfe_pkg::fold_byte(pattern[8*i +: 8]) !=
                    dfe_pkg::fold_byte(window[8*(l-1-i) +: 8]))
                begin
                    hit_by_len[l] = 1'b0;
                end
            end
        end
    end

    assign hit = (len <= dfe_pkg::LEN_W'(dfe_pkg::MAX_DELIM)) ? hit_by_len[len] : 1'b0;

endmodule

### dv/testbench.sv
// Self-checking testbench for delimited_field_extractor_core: directed byte table, then
// random texts under several delimiter settings, with random idling on both channels.
// Depends on dfe_pkg and the extractor RTL only.
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF     = 5;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int PHASE_ITEMS  = 75;
    localparam int PHASES       = 8;

    // Kinds of row in the directed table
    typedef enum logic [1:0] {
        ROW_BYTE,       // byte checked against the tracking model
        ROW_KNOWN,      // closing byte with its result written out by hand
        ROW_REG         // register write while the block is quiet
    } row_kind_t;

    typedef struct packed {
        row_kind_t           kind;
        dfe_pkg::text_t      txt;
        dfe_pkg::result_t    want;
        dfe_pkg::reg_index_t idx;
        logic [63:0]         data;
    } plan_row_t;

    localparam dfe_pkg::text_t   NO_TEXT   = '0;
    localparam dfe_pkg::result_t NOT_FOUND = '0;

    // Directed table. Opening delimiter "Id=" (three bytes), closing ";".
    // Garbage above the length in use must be ignored, as must length bits 63:4.
    localparam plan_row_t DIRECTED_PLAN [31] = '{
        // registers still at reset: both lengths zero, so nothing can match
        '{ROW_KNOWN, '{8'h61, 1'b1}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_KNOWN, '{8'hFF, 1'b1}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_KNOWN, '{8'h00, 1'b1}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN,  64'hC3C3_C3C3_C33D_6449},
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_OPEN_LENGTH,   64'hFFFF_FFFF_FFFF_FFF3},
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_CLOSE_PATTERN, 64'h5A5A_5A5A_5A5A_5A3B},
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_CLOSE_LENGTH,  64'h0000_0000_0000_0001},
        // "iD=;" then NUL: empty value, match already complete so it stands
        '{ROW_BYTE,  '{8'h69, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'h44, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'h3D, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'h3B, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_KNOWN, '{8'h00, 1'b1}, '{1'b1, 16'd3, 16'd0}, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        // "iD=" NUL ";": the NUL stops the search before the close
        '{ROW_BYTE,  '{8'h69, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'h44, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'h3D, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'h00, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_KNOWN, '{8'h3B, 1'b1}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        // all-ones delimiters, opening length 15 clipped to 8, closing off
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN,  64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_OPEN_LENGTH,   64'h0000_0000_0000_000F},
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_CLOSE_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_CLOSE_LENGTH,  64'h0000_0000_0000_0000},
        '{ROW_BYTE,  '{8'hFF, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'hFF, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'hFF, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'hFF, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'hFF, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'hFF, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'hFF, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        '{ROW_BYTE,  '{8'hFF, 1'b0}, NOT_FOUND, dfe_pkg::REG_OPEN_PATTERN, 64'd0},
        // closing length switched on mid-text; close then lands on the last byte
        '{ROW_REG, NO_TEXT, NOT_FOUND, dfe_pkg::REG_CLOSE_LENGTH,  64'h0000_0000_0000_0001},
        '{ROW_KNOWN, '{8'hFF, 1'b1}, '{1'b1, 16'd8, 16'd0}, dfe_pkg::REG_OPEN_PATTERN, 64'd0}
    };

    // ---------------------------------------------------------------
    // Clock, reset and the block's ports
    // ---------------------------------------------------------------
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       text_valid   = 1'b0;
    logic                       text_stall;
    dfe_pkg::text_t             text         = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    dfe_pkg::result_t           result;
    logic                       cfg_write    = 1'b0;
    logic [dfe_pkg::IDX_W-1:0]  cfg_index    = '0;
    logic [dfe_pkg::CFG_W-1:0]  cfg_data     = '0;

    always #CLK_HALF clk = ~clk;

    delimited_field_extractor_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text         (text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ---------------------------------------------------------------
    // Tracking model: register copies and per-text search state
    // ---------------------------------------------------------------
    logic [63:0]     open_pat    = '0;
    logic [3:0]      open_len    = '0;
    logic [63:0]     close_pat   = '0;
    logic [3:0]      close_len   = '0;

    logic [dfe_pkg::WIN_W-1:0] win_bytes = '0;   // newest byte in bits 7:0
    int unsigned     next_pos    = 0;      // stops advancing at MAX_TEXT
    dfe_pkg::phase_t phase       = dfe_pkg::PH_OPEN;
    int unsigned     phase_count = 0;      // bytes since phase start, capped
    int unsigned     start_ofs   = 0;
    int unsigned     value_len   = 0;
    bit              closed_text = 1'b0;   // previous byte carried text_last

    dfe_pkg::result_t pending_extractions [$];  // oldest first
    logic [7:0]      text_bytes [$];            // text being built for sending

    bit              idling        = 1'b1;
    int              hold_left     = 0;
    int              mismatch_count = 0;
    int              cycle_count   = 0;
    int              text_count    = 0;
    dfe_pkg::result_t want;

    function automatic logic [7:0] ascii_lower(input logic [7:0] b);
        return (b inside {[8'h41:8'h5A]}) ? (b | 8'h20) : b;
    endfunction

    function automatic int unsigned clip_len(input logic [3:0] len);
        return (len > 4'(dfe_pkg::MAX_DELIM)) ? dfe_pkg::MAX_DELIM : len;
    endfunction

    // Delimiter byte 0 is the oldest of the last n bytes in the window
    function automatic bit delim_ends_window(input logic [63:0] pat, input int unsigned n);
        for (int i = 0; i < n; i++)
        begin
            if (ascii_lower(pat[8*i +: 8]) != ascii_lower(win_bytes[8*(n-1-i) +: 8]))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advance the search by one accepted byte; a byte with text_last yields a result
    task automatic track_extraction(input dfe_pkg::text_t t, output bit emits,
                                    output dfe_pkg::result_t r);
        int unsigned olen;
        int unsigned clen;
        olen = clip_len(open_len);
        clen = clip_len(close_len);
        r    = '0;

        if (closed_text)
        begin
            win_bytes   = '0;
            next_pos    = 0;
            phase       = dfe_pkg::PH_OPEN;
            phase_count = 0;
            start_ofs   = 0;
            value_len   = 0;
            closed_text = 1'b0;
        end

        // beyond MAX_TEXT the bytes still pass but are not searched
        if (next_pos < dfe_pkg::MAX_TEXT)
        begin
            if (phase == dfe_pkg::PH_OPEN || phase == dfe_pkg::PH_CLOSE)
            begin
                if (t.text_byte == 8'h00)
                begin
                    phase = dfe_pkg::PH_STOP;
                end
                else
                begin
                    win_bytes = {win_bytes[dfe_pkg::WIN_W-9:0], t.text_byte};
                    if (phase_count < dfe_pkg::MAX_DELIM)
                    begin
                        phase_count++;
                    end
                    if (phase == dfe_pkg::PH_OPEN)
                    begin
                        if (olen != 0 && phase_count >= olen
                            && delim_ends_window(open_pat, olen))
                        begin
                            start_ofs   = next_pos + 1;
                            phase       = dfe_pkg::PH_CLOSE;
                            phase_count = 0;
                        end
                    end
                    else if (clen != 0 && phase_count >= clen
                             && delim_ends_window(close_pat, clen))
                    begin
                        value_len = next_pos + 1 - clen - start_ofs;
                        phase     = dfe_pkg::PH_DONE;
                    end
                end
            end
            next_pos++;
        end

        emits = t.text_last;
        if (t.text_last)
        begin
            closed_text = 1'b1;
            // lengths are judged on the closing byte's register values
            if (phase == dfe_pkg::PH_DONE && olen != 0 && clen != 0)
            begin
                r.found        = 1'b1;
                r.value_start  = start_ofs[15:0];
                r.value_length = value_len[15:0];
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Text channel driver
    // ---------------------------------------------------------------
    // Offers one byte, holding it until a transaction takes it, then records
    // the outcome. Valid stays high into the next call unless a gap is drawn.
    task automatic send_byte(input dfe_pkg::text_t t, input bit typed,
                             input dfe_pkg::result_t typed_res);
        bit               emits;
        dfe_pkg::result_t predicted;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        text_valid <= 1'b1;
        text       <= t;
        @(posedge clk);
        while (text_stall) @(posedge clk);
        track_extraction(t, emits, predicted);
        if (emits)
        begin
            pending_extractions.push_back(typed ? typed_res : predicted);
        end
    endtask

    task automatic send_text();
        dfe_pkg::text_t t;
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            t.text_byte = text_bytes[i];
            t.text_last = (i == text_bytes.size() - 1);
            send_byte(t, 1'b0, NOT_FOUND);
        end
        text_count++;
    endtask

    // Quiet means every result in and the pipeline flushed of trailing bytes
    task automatic wait_idle();
        text_valid <= 1'b0;
        while (pending_extractions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input dfe_pkg::reg_index_t idx, input logic [63:0] data);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            dfe_pkg::REG_OPEN_PATTERN:  open_pat  = data;
            dfe_pkg::REG_OPEN_LENGTH:   open_len  = data[3:0];
            dfe_pkg::REG_CLOSE_PATTERN: close_pat = data;
            dfe_pkg::REG_CLOSE_LENGTH:  close_len = data[3:0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // Random stimulus helpers
    // ---------------------------------------------------------------
    // Delimiter bytes lean towards letters and the edges of the A-Z fold
    function automatic logic [7:0] rand_delim_byte();
        logic [7:0] edges [8] = '{8'h40, 8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
        case ($urandom_range(0, 3))
            0:       return 8'h41 + 8'($urandom_range(0, 25));
            1:       return 8'h61 + 8'($urandom_range(0, 25));
            2:       return edges[$urandom_range(0, 7)];
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // Bytes above the length in use get arbitrary junk, zero included
    function automatic logic [63:0] rand_pattern(input int unsigned n);
        logic [63:0] pat;
        for (int i = 0; i < 8; i++)
        begin
            pat[8*i +: 8] = (i < n) ? rand_delim_byte() : 8'($urandom_range(0, 255));
        end
        return pat;
    endfunction

    // Non-NUL filler; now and then a delimiter byte to provoke partial matches
    function automatic logic [7:0] pick_filler();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0, 1:    b = 8'h61 + 8'($urandom_range(0, 25));
            2:       b = 8'h41 + 8'($urandom_range(0, 25));
            3:       b = 8'($urandom_range(8'h20, 8'h40));
            4:       b = 8'($urandom_range(1, 255));
            default: b = 8'((($urandom_range(0, 1) != 0) ? open_pat : close_pat)
                            >> (8 * $urandom_range(0, 7)));
        endcase
        return (b == 8'h00) ? 8'h2C : b;
    endfunction

    // Delimiter with letters in random case
    task automatic append_delim(input logic [63:0] pat, input int unsigned n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = pat[8*i +: 8];
            if (ascii_lower(b) inside {[8'h61:8'h7A]} && $urandom_range(0, 1) != 0)
            begin
                b = b ^ 8'h20;
            end
            text_bytes.push_back(b);
        end
    endtask

    task automatic add_filler(input int n);
        repeat (n) text_bytes.push_back(pick_filler());
    endtask

    // Mostly well-formed texts with random content; the rest noise,
    // missing or truncated delimiters, repeated openings and stray NULs
    task automatic build_text();
        int          shape;
        int unsigned olen;
        int unsigned clen;
        shape = $urandom_range(0, 9);
        olen  = clip_len(open_len);
        clen  = clip_len(close_len);
        text_bytes.delete();
        if (shape == 0)
        begin
            repeat ($urandom_range(1, 12)) text_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            add_filler($urandom_range(0, 5));
            if (shape != 1)
            begin
                append_delim(open_pat, olen);
            end
            if (shape == 4)
            begin
                add_filler($urandom_range(0, 3));
                append_delim(open_pat, olen);
            end
            add_filler($urandom_range(0, 8));
            if (shape == 2 && clen != 0)
            begin
                append_delim(close_pat, clen - 1);
            end
            else
            begin
                append_delim(close_pat, clen);
            end
            add_filler($urandom_range(0, 3));
            if (shape == 3)
            begin
                text_bytes.insert($urandom_range(0, text_bytes.size()), 8'h00);
            end
        end
        if (text_bytes.size() == 0)
        begin
            text_bytes.push_back(pick_filler());
        end
    endtask

    // ---------------------------------------------------------------
    // Result channel: random stall bursts and field-by-field checking
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_extractions.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result with none expected: found %0b start %0d length %0d",
                         $time, result.found, result.value_start, result.value_length);
            end
            else
            begin
                want = pending_extractions.pop_front();
                if (result.found !== want.found)
                begin
                    mismatch_count++;
                    $display("%0t: found expected %0b, got %0b",
                             $time, want.found, result.found);
                end
                if (result.value_start !== want.value_start)
                begin
                    mismatch_count++;
                    $display("%0t: value_start expected %0d, got %0d",
                             $time, want.value_start, result.value_start);
                end
                if (result.value_length !== want.value_length)
                begin
                    mismatch_count++;
                    $display("%0t: value_length expected %0d, got %0d",
                             $time, want.value_length, result.value_length);
                end
            end
        end

        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (idling && $urandom_range(0, 4) == 0)
        begin
            hold_left = $urandom_range(1, 14) - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("delimited_field_extractor_core regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, directed table, random phases, drain
    // ---------------------------------------------------------------
    initial
    begin
        int          items;
        logic [3:0]  olen_set;
        logic [3:0]  clen_set;
        logic [63:0] junk;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PLAN[i])
        begin
            case (DIRECTED_PLAN[i].kind)
                ROW_REG:   write_reg(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].data);
                ROW_KNOWN: send_byte(DIRECTED_PLAN[i].txt, 1'b1, DIRECTED_PLAN[i].want);
                default:   send_byte(DIRECTED_PLAN[i].txt, 1'b0, NOT_FOUND);
            endcase
        end

        // Each phase: single-byte, full-width, clipped, and one side disabled,
        // then random lengths. Upper bits of the length writes carry junk.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    olen_set = 4'd1;
                    clen_set = 4'd1;
                end
                1:
                begin
                    olen_set = 4'd8;
                    clen_set = 4'd8;
                end
                2:
                begin
                    olen_set = 4'd15;
                    clen_set = 4'($urandom_range(9, 15));
                end
                3:
                begin
                    olen_set = 4'd0;
                    clen_set = 4'($urandom_range(1, 8));
                end
                4:
                begin
                    olen_set = 4'($urandom_range(1, 8));
                    clen_set = 4'd0;
                end
                default:
                begin
                    olen_set = 4'($urandom_range(1, 8));
                    clen_set = 4'($urandom_range(1, 8));
                end
            endcase
            write_reg(dfe_pkg::REG_OPEN_PATTERN, rand_pattern(clip_len(olen_set)));
            junk = {$urandom, $urandom};
            write_reg(dfe_pkg::REG_OPEN_LENGTH, {junk[63:4], olen_set});
            write_reg(dfe_pkg::REG_CLOSE_PATTERN, rand_pattern(clip_len(clen_set)));
            junk = {$urandom, $urandom};
            write_reg(dfe_pkg::REG_CLOSE_LENGTH, {junk[63:4], clen_set});

            // Final phase runs without idling
            idling = (p != PHASES - 1);
            items  = 0;
            while (items < PHASE_ITEMS)
            begin
                if (p != PHASES - 1 && text_count % 6 == 0)
                begin
                    idling = ($urandom_range(0, 3) != 0);
                end
                build_text();
                send_text();
                items += text_bytes.size();
            end
        end

        text_valid <= 1'b0;
        while (pending_extractions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("delimited_field_extractor_core regression: pass");
        end
        else
        begin
            $display("delimited_field_extractor_core regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
design/dfe_pkg.sv
design/dfe_delim_match.sv
design/delimited_field_extractor_core.sv
dv/testbench.sv
